// ----- design/sfc32_stream_generator_unit_macros.svh -----
// Assertion macros used by the SFC32 generator checker.
`ifndef SFC32_STREAM_GENERATOR_UNIT_MACROS_SVH
`define SFC32_STREAM_GENERATOR_UNIT_MACROS_SVH

// Check a property on the rising clock edge, skipped while reset is high.
`define SFC32_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on the rising clock edge, reset cycles included.
`define SFC32_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- design/sfc32_pkg.sv -----
// Shared types and constants of the SFC32 stream generator.
`timescale 1ns / 1ps

package sfc32_pkg;

   localparam int WordWidth  = 32;
   localparam int StepWidth  = 8;
   localparam int ShiftA     = 9;
   localparam int MulBShift  = 3;   // times 9 = times 8 plus one
   localparam int RotC       = 21;
   localparam int RotCBack   = 11;
   localparam int SeedRounds = 16;
   localparam int RoundWidth = $clog2(SeedRounds);

   localparam logic [StepWidth-1:0] StepReset = StepWidth'(1);

   localparam logic KIND_NEXT = 1'b0;
   localparam logic KIND_SEED = 1'b1;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [StepWidth-1:0] step_type;

   typedef struct packed {
      word_type word_a;
      word_type word_b;
      word_type word_c;
      word_type round_counter;
   } gen_state_type;

   // Commands from the request stage to the state holder.
   typedef struct packed {
      logic     next_go;
      logic     seed_go;
      word_type seed_value;
      step_type step;
   } gen_cmd_type;

endpackage

// ----- design/sfc32_round.sv -----
// One SFC32 round: output word and next generator state.
`timescale 1ns / 1ps

module sfc32_round
   import sfc32_pkg::*;
(
   input  gen_state_type cur_state,
   input  step_type      step,
   output gen_state_type nxt_state,
   output word_type      round_value
);

   word_type rot_c;

   assign round_value = cur_state.word_a + cur_state.word_b + cur_state.round_counter;
   assign rot_c = {cur_state.word_c[RotCBack-1:0], cur_state.word_c[WordWidth-1:RotCBack]};

   always_comb begin
      nxt_state.round_counter = cur_state.round_counter + WordWidth'(step);
      nxt_state.word_a        = cur_state.word_b ^ (cur_state.word_b >> ShiftA);
      nxt_state.word_b        = (cur_state.word_c << MulBShift) + cur_state.word_c;
      nxt_state.word_c        = round_value + rot_c;
   end

endmodule

// ----- design/sfc32_state.sv -----
// Generator state registers and the sixteen-round reseed sequencer.
`timescale 1ns / 1ps

module sfc32_state
   import sfc32_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  gen_cmd_type cmd,
   output word_type    round_value,
   output logic        busy
);

   gen_state_type             state_ff, state_in;
   gen_state_type             round_next;
   logic                      busy_ff, busy_in;
   logic [RoundWidth-1:0]     rounds_ff, rounds_in;

   sfc32_round u_round (
      .cur_state   (state_ff),
      .step        (cmd.step),
      .nxt_state   (round_next),
      .round_value (round_value)
   );

   always_comb begin
      state_in  = state_ff;
      busy_in   = busy_ff;
      rounds_in = rounds_ff;
      if (cmd.seed_go) begin
         state_in.word_a        = '0;
         state_in.word_b        = '0;
         state_in.word_c        = cmd.seed_value;
         state_in.round_counter = WordWidth'(cmd.step);
         busy_in                = 1'b1;
         rounds_in              = RoundWidth'(SeedRounds - 1);
      end else if (busy_ff) begin
         state_in  = round_next;
         rounds_in = rounds_ff - RoundWidth'(1);
         if (rounds_ff == '0) begin
            busy_in = 1'b0;
         end
      end else if (cmd.next_go) begin
         state_in = round_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= '0;
         busy_ff   <= 1'b0;
         rounds_ff <= '0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         rounds_ff <= rounds_in;
      end
   end

   assign busy = busy_ff;

endmodule

// ----- design/sfc32_stream_generator_unit.sv -----
// Top level of the SFC32 stream generator.
`timescale 1ns / 1ps
// SFC32 pseudo-random word generator with a selectable counter step.
// Input stream (req_): req_tuser is the kind (0 = next word, 1 = reseed),
//   req_tdata the 32-bit seed, ignored for a next request.
// Output stream (rsp_): rsp_tdata is one random word per next request;
//   a reseed request gives no result.
// Config: csr_wr_en writes csr_wr_data into the 8-bit step register
//   (reset 1); write it only while the block is idle.
// Path: a next request is taken into the request register; when it advances
//   its round runs and the result register takes the word and sets rsp_tvalid.
// Throughput: one next request per cycle while no reseed runs and rsp_tready
//   is high; the round is one three-input add and one add of the rotated c
//   word between the state registers. A reseed loads the state, then runs 16
//   discarded rounds, one per cycle; the seed leaves the request register at
//   the load, and a request queued behind it advances after the last round.
// Reset clears the generator state to zero, the step to 1 and both stages.
// When rsp_tready is low the result register holds its word and the request
//   register fills, after which req_tready drops.

module sfc32_stream_generator_unit
   import sfc32_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [WordWidth-1:0] req_tdata,   // [31:0] seed_value
   input  logic                 req_tuser,   // [0] kind
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [WordWidth-1:0] rsp_tdata,   // [31:0] random_value
   input  logic                 csr_wr_en,
   input  logic [StepWidth-1:0] csr_wr_data
);

   // Step register.
   step_type step_ff;

   // Request register.
   logic     req_valid_ff, req_valid_in;
   logic     req_kind_ff;
   word_type req_seed_ff;

   // Result register.
   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_data_ff;

   gen_cmd_type cmd;
   word_type    round_value;
   logic        busy;
   logic        out_free;
   logic        req_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= StepReset;
      end else if (csr_wr_en) begin
         step_ff <= csr_wr_data;
      end
   end

   // Result register is free when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Advance the held request: a reseed needs only the sequencer idle,
   // a next request also needs room in the result register.
   assign req_go = req_valid_ff && !busy && (req_kind_ff == KIND_SEED || out_free);

   assign req_tready = !req_valid_ff || req_go;

   always_comb begin
      cmd.next_go    = req_go && (req_kind_ff == KIND_NEXT);
      cmd.seed_go    = req_go && (req_kind_ff == KIND_SEED);
      cmd.seed_value = req_seed_ff;
      cmd.step       = step_ff;
   end

   sfc32_state u_state (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .round_value (round_value),
      .busy        (busy)
   );

   // Hold the request until it advances, then take the next one.
   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_tvalid && req_tready) begin
         req_valid_in = 1'b1;
      end else if (req_go) begin
         req_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_kind_ff <= req_tuser;
         req_seed_ff <= req_tdata;
      end
   end

   // Load a fresh word on a next round, drop the valid once it is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.next_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.next_go) begin
         rsp_data_ff <= round_value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- design/sfc32_checker.sv -----
// Port-level checks of the SFC32 stream generator, bound to the top level.
`timescale 1ns / 1ps
`include "sfc32_stream_generator_unit_macros.svh"

module sfc32_checker
   import sfc32_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 req_tuser,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [WordWidth-1:0] rsp_tdata
);

   // A stalled result keeps its word.
   `SFC32_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // No result is pending right after reset.
   `SFC32_ASSERT_RST(a_rsp_reset, reset |=> !rsp_tvalid, "result valid after reset")

   // A reseed request never raises a result of its own.
   `SFC32_ASSERT(a_seed_silent, (req_tvalid && req_tready && req_tuser == KIND_SEED) ##1 !rsp_tvalid |=> !rsp_tvalid, "reseed produced a result")

endmodule

bind sfc32_stream_generator_unit sfc32_checker u_sfc32_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
